@@ hw/rtl/ccs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the comment stripper
// Character codes, opcode values and the record that carries the results of
// one item from the scanner to the output stage.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // opcode of an input item
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // characters the scanner looks for
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // result count of one item: 0 to 5
  localparam int CNT_W = 3;

  // results of one item: first byte, second byte, zeros after that
  typedef struct packed {
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;
    logic [CNT_W-1:0] cnt;
    logic             bad;
  } ccs_job_t;

endpackage

@@ hw/rtl/ccs_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_scan: lexical scanner
// Holds the scan mode, the pending-blank flag and the output byte phase, and
// turns each accepted item into a result record for the output stage.
// ----------------------------------------------------------------------------
module ccs_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_op,
  input  logic [7:0]       in_byte,
  output ccs_pkg::ccs_job_t job_o
);

  typedef enum logic [7:0] {
    MODE_NORMAL  = 8'b0000_0001,
    MODE_STRING  = 8'b0000_0010,
    MODE_CHAR    = 8'b0000_0100,
    MODE_STRESC  = 8'b0000_1000,
    MODE_CHARESC = 8'b0001_0000,
    MODE_SLASH   = 8'b0010_0000,
    MODE_COMMENT = 8'b0100_0000,
    MODE_STAR    = 8'b1000_0000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       blank_r, blank_nxt;
  logic [1:0] phase_r, phase_nxt;

  logic       is_blank;
  logic       pre_space;
  logic       emit_c;
  logic [1:0] eof_p1;
  logic [1:0] eof_p2;
  logic [1:0] eof_pads;

  // byte classes in normal text
  assign is_blank  = (in_byte == ccs_pkg::CH_SPACE) || (in_byte == ccs_pkg::CH_TAB);
  assign pre_space = blank_r && (in_byte != ccs_pkg::CH_SPACE);
  assign emit_c    = !is_blank && (in_byte != ccs_pkg::CH_SLASH);

  // end of file: zero padding up to a four-byte boundary
  assign eof_p1   = phase_r + {1'b0, blank_r};
  assign eof_p2   = eof_p1 + 2'd1;
  assign eof_pads = 2'd0 - eof_p2;

  // next state and results of the item
  always_comb begin
    mode_nxt          = mode_r;
    blank_nxt         = blank_r;
    job_o.first_byte  = in_byte;
    job_o.second_byte = ccs_pkg::CH_NUL;
    job_o.cnt         = '0;
    job_o.bad         = 1'b0;
    if (in_op == ccs_pkg::OP_EOF) begin
      job_o.first_byte = blank_r ? ccs_pkg::CH_SPACE : ccs_pkg::CH_NUL;
      job_o.cnt        = ccs_pkg::CNT_W'(blank_r) + ccs_pkg::CNT_W'(1)
                         + ccs_pkg::CNT_W'(eof_pads);
      job_o.bad        = (mode_r != MODE_NORMAL);
      mode_nxt         = MODE_NORMAL;
      blank_nxt        = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_NORMAL: begin
          blank_nxt = is_blank;
          if (in_byte == ccs_pkg::CH_SQ) begin
            mode_nxt = MODE_CHAR;
          end else if (in_byte == ccs_pkg::CH_DQ) begin
            mode_nxt = MODE_STRING;
          end else if (in_byte == ccs_pkg::CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end
          if (pre_space) begin
            job_o.first_byte  = ccs_pkg::CH_SPACE;
            job_o.second_byte = in_byte;
            job_o.cnt         = emit_c ? ccs_pkg::CNT_W'(2) : ccs_pkg::CNT_W'(1);
          end else begin
            job_o.cnt = emit_c ? ccs_pkg::CNT_W'(1) : ccs_pkg::CNT_W'(0);
          end
        end
        MODE_STRING: begin
          job_o.cnt = ccs_pkg::CNT_W'(1);
          if (in_byte == ccs_pkg::CH_DQ) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_byte == ccs_pkg::CH_BSL) begin
            mode_nxt = MODE_STRESC;
          end
        end
        MODE_CHAR: begin
          job_o.cnt = ccs_pkg::CNT_W'(1);
          if (in_byte == ccs_pkg::CH_SQ) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_byte == ccs_pkg::CH_BSL) begin
            mode_nxt = MODE_CHARESC;
          end
        end
        MODE_STRESC: begin
          job_o.cnt = ccs_pkg::CNT_W'(1);
          mode_nxt  = MODE_STRING;
        end
        MODE_CHARESC: begin
          job_o.cnt = ccs_pkg::CNT_W'(1);
          mode_nxt  = MODE_CHAR;
        end
        MODE_SLASH: begin
          if (in_byte == ccs_pkg::CH_STAR) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            // lone slash goes out ahead of this byte
            job_o.first_byte  = ccs_pkg::CH_SLASH;
            job_o.second_byte = in_byte;
            job_o.cnt         = ccs_pkg::CNT_W'(2);
            if (in_byte == ccs_pkg::CH_SQ) begin
              mode_nxt = MODE_CHAR;
            end else if (in_byte == ccs_pkg::CH_DQ) begin
              mode_nxt = MODE_STRING;
            end else begin
              mode_nxt = MODE_NORMAL;
            end
          end
        end
        MODE_COMMENT: begin
          if (in_byte == ccs_pkg::CH_STAR) begin
            mode_nxt = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (in_byte == ccs_pkg::CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_byte != ccs_pkg::CH_STAR) begin
            mode_nxt = MODE_COMMENT;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end
  end

  // byte phase follows the number of bytes emitted
  assign phase_nxt = (in_op == ccs_pkg::OP_EOF) ? 2'd0 : phase_r + job_o.cnt[1:0];

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      blank_r <= 1'b0;
      phase_r <= 2'd0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      blank_r <= blank_nxt;
      phase_r <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  // a blank can only be pending in normal text
  a_blank_normal: assert property (@(posedge clk) disable iff (!rst_n)
    blank_r |-> (mode_r == MODE_NORMAL))
    else $error("ccs_scan: blank pending outside normal text");

  // end of file leaves the output aligned and the scanner in normal text
  a_eof_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == ccs_pkg::OP_EOF)) |=>
      (phase_r == 2'd0) && (mode_r == MODE_NORMAL) && !blank_r)
    else $error("ccs_scan: state not cleared after end of file");
`endif

endmodule

@@ hw/rtl/ccs_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_emit: result sequencer and output register
// Holds the record of one item and hands its bytes one by one to the output
// register; frees the record as its last byte moves out.
// ----------------------------------------------------------------------------
module ccs_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  ccs_pkg::ccs_job_t job_i,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_unterminated
);

  logic                      job_vld_r;
  logic [7:0]                job_a_r;
  logic [7:0]                job_b_r;
  logic [ccs_pkg::CNT_W-1:0] job_rem_r;
  logic                      job_bad_r;

  logic                      out_vld_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r;
  logic                      out_bad_r;

  logic                      out_load;
  logic                      job_done;
  logic                      job_wr;

  // move a byte when the output register is empty or being drained
  assign out_load = job_vld_r && (!out_vld_r || out_ready);
  assign job_done = out_load && (job_rem_r == ccs_pkg::CNT_W'(1));
  assign in_ready = !job_vld_r || job_done;
  assign job_wr   = in_fire && (job_i.cnt != '0);

  // record of the item being emitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else if (job_wr) begin
      job_vld_r <= 1'b1;
    end else if (job_done) begin
      job_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_wr) begin
      job_a_r   <= job_i.first_byte;
      job_b_r   <= job_i.second_byte;
      job_rem_r <= job_i.cnt;
      job_bad_r <= job_i.bad;
    end else if (out_load) begin
      job_a_r   <= job_b_r;
      job_b_r   <= ccs_pkg::CH_NUL;
      job_rem_r <= job_rem_r - ccs_pkg::CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= job_a_r;
      out_last_r <= (job_rem_r == ccs_pkg::CNT_W'(1));
      out_bad_r  <= job_bad_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_unterminated = out_bad_r;

`ifndef SYNTHESIS
  // a held record always has between one and five bytes left
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r |-> (job_rem_r != '0) && (job_rem_r <= ccs_pkg::CNT_W'(5)))
    else $error("ccs_emit: remaining byte count out of range");

  // the bytes of one item follow each other without a gap
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && !out_last_r) |=> out_vld_r)
    else $error("ccs_emit: gap inside the results of one item");
`endif

endmodule

@@ hw/rtl/c_comment_stripper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper_top: streaming C block comment remover
// Input items carry one source byte (in_op = 0) or an end-of-file mark
// (in_op = 1) on a valid/ready channel. Output items are the stripped bytes,
// one per item, with out_last on the final byte caused by an input item.
// An end-of-file mark emits any pending blank, a zero terminator and zero
// padding to a four-byte boundary; out_unterminated is set on those bytes
// when the file ended inside a comment, a literal or right after a slash.
// The results of an item are registered in the result record and then move
// on into the output register whenever it is free. Throughput: an item that
// causes n results holds its record until the last of them moves out; items
// with zero or one result go at one per cycle while out_ready stays high.
// The result record register and the output register sit between the two
// channels, so a new item is taken while the last byte of the previous item
// waits. When the receiver stalls, the output byte holds and in_ready drops
// once a record is waiting behind it. Synchronous reset (rst_n low) returns
// the scanner to normal text with no blank pending and empties both
// registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module c_comment_stripper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_unterminated
);

  logic              in_fire;
  ccs_pkg::ccs_job_t job;

  assign in_fire = in_valid && in_ready;

  // scanner: state and per-item results
  ccs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_op),
    .in_byte (in_byte),
    .job_o   (job)
  );

  // sequencer and output register
  ccs_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .job_i            (job),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_unterminated (out_unterminated)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for c_comment_stripper_top
// A short table of directed items (byte extremes, blank folding, slash,
// comment, string and char literal handling, end of file with and without
// an error) is followed by random C-like text. Each accepted item runs
// through a local scanner model; its expected bytes, or the table's own
// bytes on typed rows, are compared, in order and field by field, with every
// byte taken from the output channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 384;
  localparam int DRAIN_CYC   = 10;
  localparam int MAX_RES     = 5;
  localparam int DIR_N       = 26;

  // scanner modes of the local model
  typedef enum logic [7:0] {
    SCAN_TEXT     = 8'b0000_0001,
    SCAN_STR      = 8'b0000_0010,
    SCAN_CHR      = 8'b0000_0100,
    SCAN_STR_ESC  = 8'b0000_1000,
    SCAN_CHR_ESC  = 8'b0001_0000,
    SCAN_SLASH    = 8'b0010_0000,
    SCAN_CMT      = 8'b0100_0000,
    SCAN_CMT_STAR = 8'b1000_0000
  } scan_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } strip_out_t;

  // one row of the directed table; exp holds up to four bytes, first byte low
  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] exp;
    logic        bad;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = ccs_pkg::OP_BYTE;
  logic [7:0] in_byte = ccs_pkg::CH_NUL;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_unterminated;

  // model state
  scan_t      txt_mode = SCAN_TEXT;
  logic       blank_held = 1'b0;
  logic [1:0] pad_phase = 2'd0;

  strip_out_t item_res[$];
  strip_out_t stripped_q[$];
  strip_out_t exp_r;
  logic [8:0] stim_q[$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  dir_row_t dir_tab [DIR_N] = '{
    '{ccs_pkg::OP_BYTE, 8'h41, 1'b1, 3'd1, 32'h0000_0041, 1'b0},  // plain byte
    '{ccs_pkg::OP_BYTE, 8'h00, 1'b1, 3'd1, 32'h0000_0000, 1'b0},  // lowest byte
    '{ccs_pkg::OP_BYTE, 8'hFF, 1'b1, 3'd1, 32'h0000_00FF, 1'b0},  // highest byte
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SPACE, 1'b1, 3'd0, 32'h0000_0000, 1'b0},  // blank held
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SPACE, 1'b1, 3'd0, 32'h0000_0000, 1'b0},  // then space
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_TAB,   1'b1, 3'd1, 32'h0000_0020, 1'b0},  // then tab
    '{ccs_pkg::OP_BYTE, 8'h78,             1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH, 1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH, 1'b0, 3'd0, 32'h0, 1'b0},  // slash slash
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH, 1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_DQ,    1'b0, 3'd0, 32'h0, 1'b0},  // slash opens string
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_BSL,   1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_DQ,    1'b0, 3'd0, 32'h0, 1'b0},  // escaped quote
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_DQ,    1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ,    1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_BSL,   1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ,    1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ,    1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH, 1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_STAR,  1'b0, 3'd0, 32'h0, 1'b0},  // comment opens
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_STAR,  1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_EOF,  8'hA5,             1'b0, 3'd0, 32'h0, 1'b0},  // eof in comment
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH, 1'b0, 3'd0, 32'h0, 1'b0},
    '{ccs_pkg::OP_EOF,  8'h5A, 1'b1, 3'd4, 32'h0000_0000, 1'b1},  // eof after slash
    '{ccs_pkg::OP_BYTE, ccs_pkg::CH_SPACE, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{ccs_pkg::OP_EOF,  8'hFF, 1'b1, 3'd4, 32'h0000_0020, 1'b0}   // eof flushes blank
  };

  c_comment_stripper_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_unterminated (out_unterminated)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------
  function automatic void emit_byte(input logic [7:0] b);
    if (item_res.size() < MAX_RES) begin
      item_res.push_back('{data: b, last: 1'b0, bad: 1'b0});
      pad_phase = pad_phase + 2'd1;
    end
  endfunction

  // byte in normal text once any held blank is settled
  function automatic void text_byte(input logic [7:0] c);
    if (c == ccs_pkg::CH_SPACE || c == ccs_pkg::CH_TAB) begin
      blank_held = 1'b1;
    end else if (c == ccs_pkg::CH_SQ) begin
      emit_byte(c);
      txt_mode = SCAN_CHR;
    end else if (c == ccs_pkg::CH_DQ) begin
      emit_byte(c);
      txt_mode = SCAN_STR;
    end else if (c == ccs_pkg::CH_SLASH) begin
      txt_mode = SCAN_SLASH;
    end else begin
      emit_byte(c);
    end
  endfunction

  // fills item_res with the bytes one item causes
  function automatic void predict_strip(input logic op, input logic [7:0] c);
    logic bad;
    item_res.delete();
    if (op == ccs_pkg::OP_EOF) begin
      bad = (txt_mode != SCAN_TEXT);
      if (blank_held) emit_byte(ccs_pkg::CH_SPACE);
      blank_held = 1'b0;
      emit_byte(ccs_pkg::CH_NUL);
      while (pad_phase != 2'd0 && item_res.size() < MAX_RES) emit_byte(ccs_pkg::CH_NUL);
      foreach (item_res[k]) item_res[k].bad = bad;
      txt_mode = SCAN_TEXT;
    end else begin
      case (txt_mode)
        SCAN_TEXT: begin
          if (blank_held) begin
            if (c != ccs_pkg::CH_SPACE) emit_byte(ccs_pkg::CH_SPACE);
            blank_held = 1'b0;
          end
          text_byte(c);
        end
        SCAN_STR: begin
          emit_byte(c);
          if (c == ccs_pkg::CH_DQ) txt_mode = SCAN_TEXT;
          else if (c == ccs_pkg::CH_BSL) txt_mode = SCAN_STR_ESC;
        end
        SCAN_CHR: begin
          emit_byte(c);
          if (c == ccs_pkg::CH_SQ) txt_mode = SCAN_TEXT;
          else if (c == ccs_pkg::CH_BSL) txt_mode = SCAN_CHR_ESC;
        end
        SCAN_STR_ESC: begin
          emit_byte(c);
          txt_mode = SCAN_STR;
        end
        SCAN_CHR_ESC: begin
          emit_byte(c);
          txt_mode = SCAN_CHR;
        end
        SCAN_SLASH: begin
          if (c == ccs_pkg::CH_STAR) begin
            txt_mode = SCAN_CMT;
          end else begin
            // held slash goes out ahead of this byte
            emit_byte(ccs_pkg::CH_SLASH);
            emit_byte(c);
            if (c == ccs_pkg::CH_SQ) txt_mode = SCAN_CHR;
            else if (c == ccs_pkg::CH_DQ) txt_mode = SCAN_STR;
            else txt_mode = SCAN_TEXT;
          end
        end
        SCAN_CMT: begin
          if (c == ccs_pkg::CH_STAR) txt_mode = SCAN_CMT_STAR;
        end
        default: begin
          if (c == ccs_pkg::CH_SLASH) txt_mode = SCAN_TEXT;
          else if (c != ccs_pkg::CH_STAR) txt_mode = SCAN_CMT;
        end
      endcase
    end
    if (item_res.size() > 0) item_res[item_res.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // queue one C-like fragment: word, blanks, comment, literal, slash, noise or end of file
  function automatic void add_fragment();
    int r;
    int len;
    int kind;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      len = $urandom_range(1, 6);
      repeat (len) stim_q.push_back({ccs_pkg::OP_BYTE, letter()});
    end else if (r < 38) begin
      len = $urandom_range(1, 3);
      repeat (len) begin
        stim_q.push_back({ccs_pkg::OP_BYTE,
                          ($urandom_range(0, 1) != 0) ? ccs_pkg::CH_SPACE : ccs_pkg::CH_TAB});
      end
    end else if (r < 52) begin
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH});
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_STAR});
      len = $urandom_range(0, 6);
      repeat (len) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_STAR});
          1: stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH});
          2: stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SPACE});
          default: stim_q.push_back({ccs_pkg::OP_BYTE, letter()});
        endcase
      end
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_STAR});
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH});
    end else if (r < 64) begin
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_DQ});
      len = $urandom_range(0, 5);
      repeat (len) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_BSL});
            stim_q.push_back({ccs_pkg::OP_BYTE, 8'($urandom_range(0, 255))});
          end
          1: stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ});
          default: stim_q.push_back({ccs_pkg::OP_BYTE, letter()});
        endcase
      end
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_DQ});
    end else if (r < 72) begin
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ});
      if ($urandom_range(0, 1) != 0) begin
        stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_BSL});
        stim_q.push_back({ccs_pkg::OP_BYTE, 8'($urandom_range(0, 255))});
      end else begin
        stim_q.push_back({ccs_pkg::OP_BYTE, letter()});
      end
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SQ});
    end else if (r < 80) begin
      stim_q.push_back({ccs_pkg::OP_BYTE, ccs_pkg::CH_SLASH});
      stim_q.push_back({ccs_pkg::OP_BYTE, 8'($urandom_range(0, 255))});
    end else if (r < 94) begin
      len = $urandom_range(1, 3);
      repeat (len) stim_q.push_back({ccs_pkg::OP_BYTE, 8'($urandom_range(0, 255))});
    end else begin
      stim_q.push_back({ccs_pkg::OP_EOF, 8'($urandom_range(0, 255))});
    end
  endfunction

  // offer one item, wait for acceptance, record what it should produce
  task automatic send_item(input logic op, input logic [7:0] data, input logic typed,
                           input int n, input logic [31:0] exp, input logic bad);
    int gap;
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= data;
    do @(posedge clk); while (!in_ready);
    predict_strip(op, data);
    if (typed) begin
      for (int k = 0; k < n; k++)
        stripped_q.push_back('{data: exp[8*k +: 8], last: (k == n - 1), bad: bad});
    end else begin
      foreach (item_res[k]) stripped_q.push_back(item_res[k]);
    end
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (stripped_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  initial begin
    logic [8:0] item;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].typed,
                int'(dir_tab[i].n), dir_tab[i].exp, dir_tab[i].bad);

    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // hold off until the output side has caught up
      if (i == RAND_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      no_idle <= (i >= 120 && i < 180);
      if (stim_q.size() == 0) add_fragment();
      // rare end of file, also in the middle of a fragment
      if ($urandom_range(0, 199) == 0) item = {ccs_pkg::OP_EOF, 8'($urandom_range(0, 255))};
      else item = stim_q.pop_front();
      send_item(item[8], item[7:0], 1'b0, 0, 32'h0, 1'b0);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // output check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (stripped_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected item: expected none, actual byte=%02h last=%0b unterm=%0b",
                 $time, out_byte, out_last, out_unterminated);
      end else begin
        exp_r = stripped_q.pop_front();
        if (out_byte !== exp_r.data) begin
          err_cnt++;
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, exp_r.data, out_byte);
        end
        if (out_last !== exp_r.last) begin
          err_cnt++;
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, exp_r.last, out_last);
        end
        if (out_unterminated !== exp_r.bad) begin
          err_cnt++;
          $display("%0t: out_unterminated mismatch: expected %0b, actual %0b",
                   $time, exp_r.bad, out_unterminated);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
